// ===== design/sync_word_length_deframer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// sync_word_length_deframer_unit_assert.svh
// Assertion macros for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SYNC_WORD_LENGTH_DEFRAMER_UNIT_ASSERT_SVH
`define SYNC_WORD_LENGTH_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SWDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define SWDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/swdf_pkg.sv =====
// ----------------------------------------------------------------------------
// swdf_pkg
// Shared constants and types of the sync word / length deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package swdf_pkg;

   // packet layout
   localparam int HEADER_BYTES  = 57;
   localparam int LENGTH_OFFSET = 53;
   localparam int LENGTH_BYTES  = 4;

   // header position counter width and its one-bit-wider compare form
   localparam int POS_W = 8;

   localparam logic [POS_W:0] LEN_LO  = (POS_W + 1)'(LENGTH_OFFSET);
   localparam logic [POS_W:0] LEN_HI  = (POS_W + 1)'(LENGTH_OFFSET + LENGTH_BYTES);
   localparam logic [POS_W:0] HDR_END = (POS_W + 1)'(HEADER_BYTES);

   // stream framing modes
   typedef enum logic [1:0] {
      MODE_HUNT   = 2'd0,
      MODE_HEADER = 2'd1,
      MODE_BODY   = 2'd2
   } mode_type;

   // what the framing core makes of the byte it is looking at
   typedef struct packed {
      logic        hit;   // start word found, four-byte burst follows
      logic        pass;  // byte passes through as one result
      logic        last;  // byte ends the packet
      logic [7:0]  data;  // the byte itself
      logic [31:0] word;  // window contents on a hit
   } core_rsp_type;

endpackage

`default_nettype wire

// ===== design/swdf_core.sv =====
// ----------------------------------------------------------------------------
// swdf_core
// Framing state: sync hunt window, header position, body length and body
// count. Evaluates the current byte combinationally, updates on go.
// ----------------------------------------------------------------------------
`default_nettype none

module swdf_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  go,
   input  wire logic [7:0]            in_byte,
   input  wire logic [31:0]           start_word,
   output swdf_pkg::core_rsp_type     rsp
);

   import swdf_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [31:0]            window_ff, window_in;
   logic [2:0]             fill_ff, fill_in;
   logic [POS_W-1:0]       header_pos_ff, header_pos_in;
   logic [31:0]            body_length_ff, body_length_in;
   logic [31:0]            body_remaining_ff, body_remaining_in;

   logic [31:0]            window_shift;
   logic                   match;
   logic [POS_W:0]         pos_ext;
   logic [POS_W:0]         pos_next;
   logic                   in_len;
   logic [31:0]            blen_shift;
   logic                   hdr_done;
   logic [31:0]            rem_dec;
   logic                   body_done;

   // per-byte evaluation
   always_comb begin
      window_shift = {window_ff[23:0], in_byte};
      match        = (fill_ff >= 3'd3) && (window_shift == start_word);
      pos_ext      = {1'b0, header_pos_ff};
      pos_next     = pos_ext + (POS_W + 1)'(1);
      in_len       = (pos_ext >= LEN_LO) && (pos_ext < LEN_HI);
      blen_shift   = in_len ? {body_length_ff[23:0], in_byte} : body_length_ff;
      hdr_done     = (pos_next >= HDR_END);
      rem_dec      = body_remaining_ff - 32'd1;
      body_done    = (rem_dec == 32'd0);
   end

   // next mode
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         MODE_HEADER: begin
            if (hdr_done) begin
               mode_in = (blen_shift == 32'd0) ? MODE_HUNT : MODE_BODY;
            end
         end
         MODE_BODY: begin
            if (body_done) begin
               mode_in = MODE_HUNT;
            end
         end
         default: begin
            if (match) begin
               mode_in = MODE_HEADER;
            end
         end
      endcase
   end

   // result and datapath updates
   always_comb begin
      rsp.hit           = 1'b0;
      rsp.pass          = 1'b0;
      rsp.last          = 1'b0;
      rsp.data          = in_byte;
      rsp.word          = window_shift;
      window_in         = window_ff;
      fill_in           = fill_ff;
      header_pos_in     = header_pos_ff;
      body_length_in    = body_length_ff;
      body_remaining_in = body_remaining_ff;
      unique case (mode_ff)
         MODE_HEADER: begin
            rsp.pass       = 1'b1;
            header_pos_in  = pos_next[POS_W-1:0];
            body_length_in = blen_shift;
            if (hdr_done) begin
               body_remaining_in = blen_shift;
               rsp.last          = (blen_shift == 32'd0);
            end
         end
         MODE_BODY: begin
            rsp.pass          = 1'b1;
            rsp.last          = body_done;
            body_remaining_in = rem_dec;
         end
         default: begin
            if (match) begin
               rsp.hit           = 1'b1;
               header_pos_in     = POS_W'(LENGTH_BYTES);
               body_length_in    = 32'd0;
               body_remaining_in = 32'd0;
               window_in         = 32'd0;
               fill_in           = 3'd0;
            end else begin
               window_in = window_shift;
               fill_in   = (fill_ff >= 3'd4) ? 3'd4 : fill_ff + 3'd1;
            end
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_HUNT;
         window_ff         <= '0;
         fill_ff           <= '0;
         header_pos_ff     <= '0;
         body_length_ff    <= '0;
         body_remaining_ff <= '0;
      end else if (go) begin
         mode_ff           <= mode_in;
         window_ff         <= window_in;
         fill_ff           <= fill_in;
         header_pos_ff     <= header_pos_in;
         body_length_ff    <= body_length_in;
         body_remaining_ff <= body_remaining_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sync_word_length_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// sync_word_length_deframer_unit
// Sync word hunt and length-prefixed packet recovery on a byte stream.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle, unless req_stall holds them, via an input
// register; results leave from the output register. Header and body bytes flow
// at one byte per cycle while rsp_stall is low. A start-word match releases
// the four window bytes as four results from the output stage; until they
// are out, a queued byte that yields output waits; hunt bytes that miss keep
// flowing. No clearing pass follows reset. Write csr only while idle.
`default_nettype none

module sync_word_length_deframer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_in_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_pkt_first,
   output      logic        rsp_pkt_last,
   output      logic        rsp_run_last,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   import swdf_pkg::*;

   `include "sync_word_length_deframer_unit_assert.svh"

   logic [31:0]   start_word_ff;
   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_first_ff, rsp_first_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_run_ff, rsp_run_in;
   logic [23:0]   burst_ff, burst_in;
   logic [1:0]    burst_cnt_ff, burst_cnt_in;

   core_rsp_type  core_rsp;
   logic          out_take;
   logic          out_free;
   logic          needs_out;
   logic          proc_go;
   logic          req_take;

   // framing core
   swdf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .go         (proc_go),
      .in_byte    (in_byte_ff),
      .start_word (start_word_ff),
      .rsp        (core_rsp)
   );

   // handshake decisions
   always_comb begin
      out_take  = !rsp_valid_ff || !rsp_stall;
      out_free  = out_take && (burst_cnt_ff == 2'd0);
      needs_out = core_rsp.hit || core_rsp.pass;
      proc_go   = in_valid_ff && (out_free || !needs_out);
      req_stall = in_valid_ff && !proc_go;
      req_take  = req_valid && !req_stall;
   end

   // input register next state
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
   end

   // output register and burst next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_run_in   = rsp_run_ff;
      burst_in     = burst_ff;
      burst_cnt_in = burst_cnt_ff;
      if ((burst_cnt_ff != 2'd0) && out_take) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = burst_ff[23:16];
         rsp_first_in = 1'b0;
         rsp_last_in  = 1'b0;
         rsp_run_in   = (burst_cnt_ff == 2'd1);
         burst_in     = {burst_ff[15:0], 8'd0};
         burst_cnt_in = burst_cnt_ff - 2'd1;
      end else if (proc_go && core_rsp.hit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = core_rsp.word[31:24];
         rsp_first_in = 1'b1;
         rsp_last_in  = 1'b0;
         rsp_run_in   = 1'b0;
         burst_in     = core_rsp.word[23:0];
         burst_cnt_in = 2'd3;
      end else if (proc_go && core_rsp.pass) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = core_rsp.data;
         rsp_first_in = 1'b0;
         rsp_last_in  = core_rsp.last;
         rsp_run_in   = 1'b1;
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_word_ff <= '0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         burst_cnt_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            start_word_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         burst_cnt_ff <= burst_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      rsp_byte_ff  <= rsp_byte_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_run_ff   <= rsp_run_in;
      burst_ff     <= burst_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_pkt_first = rsp_first_ff;
   assign rsp_pkt_last  = rsp_last_ff;
   assign rsp_run_last  = rsp_run_ff;

   // checks
   `SWDF_ASSERT_NOW(a_burst_has_out, clock, reset, burst_cnt_ff != 2'd0, rsp_valid_ff, "burst pending without valid output")
   `SWDF_ASSERT_NOW(a_no_overlap, clock, reset, proc_go && needs_out, burst_cnt_ff == 2'd0, "new output while burst pending")
   `SWDF_ASSERT_NEXT(a_hit_loads, clock, reset, proc_go && core_rsp.hit, rsp_pkt_first && (burst_cnt_ff == 2'd3), "match did not start burst")

endmodule

`default_nettype wire
